// ----- design/cma_pkg.sv -----
// Shared types and constants for the centered moving average block.
// Used by every module of the block; depends on nothing else.
package cma_pkg;

    localparam int SAMPLE_W       = 24;
    localparam int HALF_W         = 4;
    localparam int SEEN_W         = 5;
    localparam int DIV_W          = 5;
    localparam int DIV_STEPS      = 7;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
    localparam int MAX_HALF_DEF   = 15;

    localparam logic [SEEN_W-1:0] SEEN_MAX   = '1;
    localparam logic [HALF_W-1:0] HALF_RESET = 4'd1;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       emit;
        logic                       tail;
    } t_cmd;

    typedef struct packed {
        logic              clear;
        logic [HALF_W-1:0] half;
    } t_ctl;

endpackage

// ----- design/cma_front.sv -----
// Front end: accepts sample requests, tracks the vector position and expands
// the final sample into flush commands. Depends on cma_pkg.
module cma_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  cma_pkg::t_ctl                       i_ctl,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [cma_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                                i_last,
    input  logic                                i_full,
    output logic                                o_push,
    output cma_pkg::t_cmd                       o_cmd
);

    logic                         r_flush;
    logic [cma_pkg::SEEN_W-1:0]   r_seen;
    logic [cma_pkg::HALF_W-1:0]   r_fcnt;
    logic                         w_accept;
    logic                         w_fpush;
    logic                         w_emit;
    logic [cma_pkg::SEEN_W-1:0]   w_seen_inc;
    logic [cma_pkg::SEEN_W-1:0]   w_half_ext;
    logic [cma_pkg::HALF_W-1:0]   w_flen;

    assign o_ready    = !r_flush && !i_full;
    assign w_accept   = i_valid && o_ready;
    assign w_fpush    = r_flush && !i_full;
    assign o_push     = w_accept || w_fpush;
    assign w_half_ext = cma_pkg::SEEN_W'(i_ctl.half);
    assign w_seen_inc = (r_seen == cma_pkg::SEEN_MAX) ? r_seen : r_seen + 1'b1;
    assign w_emit     = r_seen >= w_half_ext;
    assign w_flen     = (w_seen_inc < w_half_ext) ? cma_pkg::HALF_W'(w_seen_inc)
                                                  : i_ctl.half;

    always_comb begin
        if (r_flush) begin
            o_cmd.sample = '0;
            o_cmd.emit   = 1'b1;
            o_cmd.tail   = r_fcnt == cma_pkg::HALF_W'(1);
        end else begin
            o_cmd.sample = i_sample;
            o_cmd.emit   = w_emit;
            o_cmd.tail   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_flush <= 1'b0;
            r_seen  <= '0;
        end else begin
            if (w_accept) begin
                if (i_last) begin
                    r_flush <= 1'b1;
                    r_seen  <= '0;
                end else begin
                    r_seen  <= w_seen_inc;
                end
            end
            if (w_fpush && r_fcnt == cma_pkg::HALF_W'(1)) begin
                r_flush <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && i_last) begin
            r_fcnt <= w_flen;
        end else if (w_fpush) begin
            r_fcnt <= r_fcnt - 1'b1;
        end
    end

endmodule

// ----- design/cma_fifo.sv -----
// Short command queue between the front end and the back end.
// Depends on cma_pkg for the command type and queue depth.
module cma_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_clear,
    input  logic          i_push,
    input  cma_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output cma_pkg::t_cmd o_cmd,
    output logic          o_full,
    output logic          o_empty
);

    cma_pkg::t_cmd                r_mem [cma_pkg::QUEUE_DEPTH];
    logic [cma_pkg::QPTR_W-1:0]   r_wp;
    logic [cma_pkg::QPTR_W-1:0]   r_rp;
    logic [cma_pkg::QPTR_W:0]     r_cnt;

    assign o_full  = r_cnt == (cma_pkg::QPTR_W + 1)'(cma_pkg::QUEUE_DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule

// ----- design/cma_back.sv -----
// Back end: sample delay line, running window sum, multi-cycle divider by the
// window size and the output register. Depends on cma_pkg.
module cma_back #(
    parameter int MAX_HALF_WINDOW = cma_pkg::MAX_HALF_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  cma_pkg::t_ctl                       i_ctl,
    input  logic                                i_empty,
    output logic                                o_pop,
    input  cma_pkg::t_cmd                       i_cmd,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [cma_pkg::SAMPLE_W-1:0] o_smoothed,
    output logic                                o_last_out
);

    localparam int LINE_DEPTH = 2 * MAX_HALF_WINDOW + 1;
    localparam int LIDX_W     = $clog2(LINE_DEPTH);
    localparam int SUM_W      = cma_pkg::SAMPLE_W + $clog2(LINE_DEPTH);
    localparam int MAG_W      = SUM_W - 1;
    localparam int DIV_CYC    = (MAG_W + cma_pkg::DIV_STEPS - 1) / cma_pkg::DIV_STEPS;
    localparam int PAD_W      = DIV_CYC * cma_pkg::DIV_STEPS;
    localparam int CNT_W      = $clog2(DIV_CYC + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_WB   = 2'd2;

    logic signed [cma_pkg::SAMPLE_W-1:0] r_line [LINE_DEPTH];
    logic signed [SUM_W-1:0]             r_sum;
    logic [1:0]                          r_state;
    logic [CNT_W-1:0]                    r_cnt;
    logic                                r_ov;
    logic signed [cma_pkg::SAMPLE_W-1:0] r_os;
    logic                                r_ol;
    logic [PAD_W-1:0]                    r_quo;
    logic [cma_pkg::DIV_W-1:0]           r_rem;
    logic [cma_pkg::DIV_W-1:0]           r_div;
    logic                                r_neg;
    logic                                r_tail;

    logic [LIDX_W-1:0]                   w_lidx;
    logic signed [cma_pkg::SAMPLE_W-1:0] w_leave;
    logic signed [SUM_W-1:0]             w_sum;
    logic signed [SUM_W-1:0]             w_abs;
    logic [MAG_W-1:0]                    w_mag;
    logic                                w_neg;
    logic [PAD_W-1:0]                    n_quo;
    logic [cma_pkg::DIV_W-1:0]           n_rem;
    logic signed [cma_pkg::SAMPLE_W-1:0] w_q;
    logic                                w_wb;

    assign o_pop      = (r_state == S_IDLE) && !i_empty;
    assign o_valid    = r_ov;
    assign o_smoothed = r_os;
    assign o_last_out = r_ol;

    assign w_lidx  = LIDX_W'({i_ctl.half, 1'b0});
    assign w_leave = r_line[w_lidx];
    assign w_sum   = r_sum + SUM_W'(i_cmd.sample) - SUM_W'(w_leave);
    assign w_neg   = w_sum[SUM_W-1];
    assign w_abs   = w_neg ? -w_sum : w_sum;
    assign w_mag   = w_abs[MAG_W-1:0];
    assign w_q     = r_quo[cma_pkg::SAMPLE_W-1:0];
    assign w_wb    = (r_state == S_WB) && (!r_ov || i_ready);

    always_comb begin
        logic [cma_pkg::DIV_W:0] rem;
        logic [PAD_W-1:0]        q;
        rem = {1'b0, r_rem};
        q   = r_quo;
        for (int k = 0; k < cma_pkg::DIV_STEPS; k++) begin
            rem = {rem[cma_pkg::DIV_W-1:0], q[PAD_W-1]};
            q   = {q[PAD_W-2:0], 1'b0};
            if (rem >= {1'b0, r_div}) begin
                rem  = rem - {1'b0, r_div};
                q[0] = 1'b1;
            end
        end
        n_quo = q;
        n_rem = rem[cma_pkg::DIV_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            for (int j = 0; j < LINE_DEPTH; j++) begin
                r_line[j] <= '0;
            end
            r_sum   <= '0;
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (w_wb) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        if (i_cmd.tail) begin
                            for (int j = 0; j < LINE_DEPTH; j++) begin
                                r_line[j] <= '0;
                            end
                            r_sum <= '0;
                        end else begin
                            r_line[0] <= i_cmd.sample;
                            for (int j = 1; j < LINE_DEPTH; j++) begin
                                r_line[j] <= r_line[j-1];
                            end
                            r_sum <= w_sum;
                        end
                        if (i_cmd.emit) begin
                            r_cnt   <= '0;
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    if (r_cnt == CNT_W'(DIV_CYC - 1)) begin
                        r_state <= S_WB;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_WB: begin
                    if (w_wb) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_cmd.emit) begin
            r_quo  <= PAD_W'(w_mag);
            r_rem  <= '0;
            r_div  <= {i_ctl.half, 1'b1};
            r_neg  <= w_neg;
            r_tail <= i_cmd.tail;
        end else if (r_state == S_DIV) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
        if (w_wb) begin
            r_os <= r_neg ? -w_q : w_q;
            r_ol <= r_tail;
        end
    end

endmodule

// ----- design/centered_moving_average.sv -----
// Top level of the centered moving average block: configuration register,
// front end, command queue and back end. Depends on cma_pkg and all cma_ modules.
//
// Zero-padded centered box filter over vectors of signed 24-bit samples, window
// 2h+1 with h written through the configuration port (0 reads as 1); a write
// clears any vector in progress. Output i appears once sample i+h is in, and
// the sample marked last flushes the remaining h outputs (fewer for short
// vectors), the final one flagged by o_last_out. The front end takes a sample
// whenever the queue has room and no flush is in progress. The back end pops a
// sample that yields no output and stays idle. For each output it runs the load,
// the seven-bit-per-cycle divider by 2h+1 and the write to the output register,
// which waits while o_valid is held unaccepted, before it pops the next sample.
module centered_moving_average #(
    parameter int MAX_HALF_WINDOW = cma_pkg::MAX_HALF_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [cma_pkg::HALF_W-1:0]          i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [cma_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                                i_last,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [cma_pkg::SAMPLE_W-1:0] o_smoothed,
    output logic                                o_last_out
);

    logic [cma_pkg::HALF_W-1:0] r_half;
    cma_pkg::t_ctl              w_ctl;
    cma_pkg::t_cmd              w_push_cmd;
    cma_pkg::t_cmd              w_pop_cmd;
    logic                       w_push;
    logic                       w_pop;
    logic                       w_full;
    logic                       w_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half <= cma_pkg::HALF_RESET;
        end else if (i_cfg_we) begin
            r_half <= i_cfg_data;
        end
    end

    always_comb begin
        w_ctl.clear = i_cfg_we;
        if (r_half == '0) begin
            w_ctl.half = cma_pkg::HALF_W'(1);
        end else if (int'(r_half) > MAX_HALF_WINDOW) begin
            w_ctl.half = cma_pkg::HALF_W'(MAX_HALF_WINDOW);
        end else begin
            w_ctl.half = r_half;
        end
    end

    cma_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_sample (i_sample),
        .i_last   (i_last),
        .i_full   (w_full),
        .o_push   (w_push),
        .o_cmd    (w_push_cmd)
    );

    cma_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (w_ctl.clear),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_pop),
        .o_cmd   (w_pop_cmd),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    cma_back #(
        .MAX_HALF_WINDOW (MAX_HALF_WINDOW)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_empty    (w_empty),
        .o_pop      (w_pop),
        .i_cmd      (w_pop_cmd),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_smoothed (o_smoothed),
        .o_last_out (o_last_out)
    );

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("Command queue written while full.");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty)
        else $error("Command queue read while empty.");

    a_cfg_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> w_empty && !o_valid)
        else $error("Configuration write left a request pending.");
`endif

endmodule
